// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the interpolator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define CCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/cci_pkg.sv -----
// Types, constants and widths for the calibration curve interpolator
`timescale 1ns / 1ps

package cci_pkg;

    // Curve geometry
    localparam int POINT_COUNT = 11;
    localparam int LEVEL_STEP  = 20;
    localparam int LEVEL_LIMIT = 200;

    localparam int POINT_W    = 16;
    localparam int LEVEL_W    = 16;
    localparam int PIDX_IN_W  = 4;
    localparam int PT_IDX_W   = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;

    localparam logic [POINT_W-1:0] FIRST_POINT  = '0;
    localparam logic [POINT_W-1:0] MAX_PT_RESET = '1;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Level split: seg = lvl / LEVEL_STEP by reciprocal multiply (exact for LVL_W bits)
    localparam int LVL_W     = $clog2(LEVEL_LIMIT + 1);
    localparam int SEG_MAX   = LEVEL_LIMIT / LEVEL_STEP;
    localparam int SEG_W     = $clog2(SEG_MAX + 2);
    localparam int REM_W     = $clog2(LEVEL_STEP + 1);
    localparam int SEG_SHIFT = LVL_W + $clog2(LEVEL_STEP);
    localparam longint unsigned SEG_MUL =
        ((64'd1 << SEG_SHIFT) + LEVEL_STEP - 1) / LEVEL_STEP;
    localparam int SEG_MUL_W = LVL_W + 1;
    localparam int SEG_PROD_W = LVL_W + SEG_MUL_W;

    // Interpolation: q = (diff * rem) / LEVEL_STEP by reciprocal multiply
    localparam int PROD_W  = POINT_W + REM_W;
    localparam int Q_SHIFT = PROD_W + $clog2(LEVEL_STEP);
    localparam longint unsigned Q_MUL =
        ((64'd1 << Q_SHIFT) + LEVEL_STEP - 1) / LEVEL_STEP;
    localparam int Q_MUL_W = PROD_W + 1;
    localparam int QF_W    = PROD_W + Q_MUL_W;

    typedef logic [POINT_W-1:0]  t_point;
    typedef logic [PT_IDX_W-1:0] t_pt_idx;

    // Input item
    typedef struct packed {
        logic                 cmd;
        logic [PIDX_IN_W-1:0] point_index;
        logic [POINT_W-1:0]   point_value;
        logic [LEVEL_W-1:0]   level;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic               ok;
        logic [POINT_W-1:0] out_value;
    } t_out_item;

    // Curve store write request
    typedef struct packed {
        logic    en;
        t_pt_idx idx;
        t_point  value;
    } t_curve_wr;

    // Curve store read-out for one segment
    typedef struct packed {
        logic   curve_ok;
        t_point lo;
        t_point hi;
        t_point last;
    } t_curve_rd;

endpackage

// ----- rtl/core/calibration_curve_interpolator.sv -----
// Top level of the calibration curve interpolator
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in) takes one item per
//   cycle while o_in_ready is high. cmd = write stores point_value at
//   point_index (ok = 0 if the index is past the last point); cmd = query
//   returns the curve interpolated at level, or ok = 0 if the level is above
//   200 or the curve shape is bad. Output channel (o_out_valid / i_out_ready,
//   payload o_out) gives exactly one result per item, in order.
//   Config: i_cfg_we / i_cfg_wdata set the point limit; write only when idle.
//   Pipeline: an item passes through the input register, curve access, rem
//   multiply, reciprocal multiply and the output register. Throughput: one
//   item per cycle sustained while i_out_ready is high.
//   Curve writes take effect in the curve-access stage, so a query right
//   behind a write already sees it.
//   Reset: curve points cleared to zero, limit set to 65535, pipeline empty.
//   Stall: results hold in place; up to five items are buffered, and
//   o_in_ready drops only when every stage is occupied.

module calibration_curve_interpolator import cci_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  t_point    i_cfg_wdata
);

    localparam logic [LVL_W-1:0] SEG_STEP = LVL_W'(LEVEL_STEP);

    // Stage valids and ready chain
    logic r_v0, r_v1, r_v2, r_v3, r_vo;
    logic rdy0, rdy1, rdy2, rdy3, rdyo;

    // Configuration
    t_point r_max_point;

    // Stage 0: decoded item
    logic                 r0_cmd;
    logic                 r0_idx_ok;
    t_pt_idx              r0_idx;
    t_point               r0_val;
    logic                 r0_lvl_ok;
    logic [LVL_W-1:0]     r0_lvl;
    logic [SEG_W-1:0]     r0_seg;
    logic                 n0_idx_ok;
    logic                 n0_lvl_ok;
    logic [SEG_PROD_W-1:0] seg_prod;

    // Stage 1: segment endpoints
    logic             r1_ok;
    t_point           r1_lo;
    t_point           r1_diff;
    logic [REM_W-1:0] r1_rem;
    logic             n1_ok;
    t_point           n1_lo;
    t_point           n1_diff;
    logic [REM_W-1:0] n1_rem;
    logic             seg_last;
    t_pt_idx          seg_idx;
    t_curve_wr        curve_wr;
    t_curve_rd        curve_rd;

    // Stage 2: product
    logic              r2_ok;
    t_point            r2_lo;
    logic [PROD_W-1:0] r2_prod;

    // Stage 3: quotient
    logic            r3_ok;
    t_point          r3_lo;
    t_point          r3_q;
    logic [QF_W-1:0] q_full;

    // Output register
    t_out_item r_out;

    // Ready chain: a stage loads when empty or when it drains this cycle
    assign rdyo = !r_vo || i_out_ready;
    assign rdy3 = !r_v3 || rdyo;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;

    assign o_in_ready  = rdy0;
    assign o_out_valid = r_vo;
    assign o_out       = r_out;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_vo        <= 1'b0;
            r_max_point <= MAX_PT_RESET;
        end else begin
            if (rdy0) r_v0 <= i_in_valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdyo) r_vo <= r_v3;
            if (i_cfg_we) r_max_point <= i_cfg_wdata;
        end
    end

    // Stage 0 decode: range checks and level / LEVEL_STEP
    always_comb begin
        n0_idx_ok = (32'(i_in.point_index) < 32'(POINT_COUNT));
        n0_lvl_ok = (32'(i_in.level) <= 32'(LEVEL_LIMIT));
        seg_prod  = SEG_PROD_W'(i_in.level[LVL_W-1:0]) * SEG_PROD_W'(SEG_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in_valid) begin
            r0_cmd    <= i_in.cmd;
            r0_idx_ok <= n0_idx_ok;
            r0_idx    <= PT_IDX_W'(i_in.point_index);
            r0_val    <= i_in.point_value;
            r0_lvl_ok <= n0_lvl_ok;
            r0_lvl    <= i_in.level[LVL_W-1:0];
            r0_seg    <= SEG_W'(seg_prod >> SEG_SHIFT);
        end
    end

    // Stage 1: curve write commits as the item moves on
    assign curve_wr.en    = r_v0 && rdy1 && (r0_cmd == CMD_WRITE) && r0_idx_ok;
    assign curve_wr.idx   = r0_idx;
    assign curve_wr.value = r0_val;

    assign seg_last = (32'(r0_seg) >= 32'(POINT_COUNT - 1));
    assign seg_idx  = seg_last ? '0 : PT_IDX_W'(r0_seg);

    cci_curve u_curve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (curve_wr),
        .i_max_point (r_max_point),
        .i_seg_idx   (seg_idx),
        .o_rd        (curve_rd)
    );

    // Stage 1: pick segment endpoints; failed or write items carry zeros
    always_comb begin
        n1_rem  = REM_W'(r0_lvl - LVL_W'(r0_seg * SEG_STEP));
        n1_lo   = '0;
        n1_diff = '0;
        if (r0_cmd == CMD_WRITE) begin
            n1_ok = r0_idx_ok;
        end else begin
            n1_ok = r0_lvl_ok && curve_rd.curve_ok;
            if (n1_ok) begin
                if (seg_last) begin
                    n1_lo = curve_rd.last;
                end else begin
                    n1_lo   = curve_rd.lo;
                    n1_diff = curve_rd.hi - curve_rd.lo;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && r_v0) begin
            r1_ok   <= n1_ok;
            r1_lo   <= n1_lo;
            r1_diff <= n1_diff;
            r1_rem  <= n1_rem;
        end
    end

    // Stage 2: rise within the segment
    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r2_ok   <= r1_ok;
            r2_lo   <= r1_lo;
            r2_prod <= PROD_W'(r1_diff) * PROD_W'(r1_rem);
        end
    end

    // Stage 3: divide the rise by LEVEL_STEP, truncating
    assign q_full = QF_W'(r2_prod) * QF_W'(Q_MUL);

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            r3_ok <= r2_ok;
            r3_lo <= r2_lo;
            r3_q  <= POINT_W'(q_full >> Q_SHIFT);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (rdyo && r_v3) begin
            r_out.ok        <= r3_ok;
            r_out.out_value <= r3_lo + r3_q;
        end
    end

    `CCI_ASSERT_IMP(a_fail_gives_zero, i_clk, i_rst_n, r_vo && !r_out.ok, r_out.out_value == '0)
    `CCI_ASSERT_IMP(a_full_blocks_input, i_clk, i_rst_n, r_vo && !i_out_ready && r_v3 && r_v2 && r_v1 && r_v0, !o_in_ready)
    `CCI_ASSERT_IMP(a_write_only_on_move, i_clk, i_rst_n, curve_wr.en, r_v0 && rdy1 && (r0_cmd == CMD_WRITE))

endmodule

// ----- rtl/core/cci_curve.sv -----
// Curve point store with shape check and segment read-out
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cci_curve import cci_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_curve_wr i_wr,
    input  t_point    i_max_point,
    input  t_pt_idx   i_seg_idx,
    output t_curve_rd o_rd
);

    t_point r_points [POINT_COUNT];
    logic   curve_ok;

    // Point registers, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POINT_COUNT; k++) begin
                r_points[k] <= '0;
            end
        end else if (i_wr.en) begin
            r_points[i_wr.idx] <= i_wr.value;
        end
    end

    // Shape check: starts at zero, bounded by the limit, non-decreasing
    always_comb begin
        curve_ok = (r_points[0] == FIRST_POINT);
        for (int k = 0; k < POINT_COUNT; k++) begin
            if (r_points[k] > i_max_point) begin
                curve_ok = 1'b0;
            end
        end
        for (int k = 1; k < POINT_COUNT; k++) begin
            if (r_points[k] < r_points[k-1]) begin
                curve_ok = 1'b0;
            end
        end
    end

    // Endpoints of the selected segment
    always_comb begin
        o_rd.curve_ok = curve_ok;
        o_rd.lo       = r_points[i_seg_idx];
        o_rd.hi       = r_points[i_seg_idx + t_pt_idx'(1)];
        o_rd.last     = r_points[POINT_COUNT-1];
    end

    `CCI_ASSERT_IMP(a_first_nonzero_fails, i_clk, i_rst_n, r_points[0] != FIRST_POINT, !o_rd.curve_ok)
    `CCI_ASSERT_NXT(a_write_lands, i_clk, i_rst_n, i_wr.en, r_points[$past(i_wr.idx)] == $past(i_wr.value))
    `CCI_ASSERT_IMP(a_last_in_limit, i_clk, i_rst_n, o_rd.curve_ok, o_rd.last <= i_max_point)

endmodule
